>>> rtl/scp_pkg.sv
// Shared constants for the second-chance page replacer.
// No dependencies; imported by the top level.
`default_nettype none

package scp_pkg;

   localparam int unsigned CSR_W     = 5;
   localparam int unsigned CSR_RESET = 16;
   localparam int unsigned FAULT_W   = 32;

endpackage : scp_pkg

`default_nettype wire

>>> rtl/scp_page_mem.sv
// Page-number store: one write port, one read port, registered read data.
// No dependencies; used by second_chance_page_replacer_unit.
`default_nettype none

module scp_page_mem #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4,
   parameter int unsigned DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : scp_page_mem

`default_nettype wire

>>> rtl/second_chance_page_replacer_unit.sv
// Second-chance (clock) page replacer: scans the page store for a hit, else sweeps the hand.
// Depends on scp_pkg and scp_page_mem.
// A hit stops the scan at the matching frame; a miss scans all n active frames, then
// the hand clears set reference bits up to the first clear frame and fills it. One item at
// a time; the next item is accepted the cycle after the result is loaded. Cost is set by the
// one read port of the page store (one frame per cycle) and the one-bit-per-cycle hand sweep.
// Reset: all frames empty, reference bits clear, hand and fault count zero, active-frame CSR 16.
`default_nettype none

module second_chance_page_replacer_unit #(
   parameter int unsigned NUM_FRAMES = 16,
   parameter int unsigned PAGE_BITS  = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [scp_pkg::CSR_W-1:0]  csr_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [PAGE_BITS-1:0]       req_page_number,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_hit,
   output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] rsp_frame_index,
   output logic                            rsp_victim_valid,
   output logic [PAGE_BITS-1:0]            rsp_victim_page,
   output logic [scp_pkg::FAULT_W-1:0]     rsp_fault_count
);

   import scp_pkg::*;

   localparam int unsigned IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int unsigned CNT_W = $clog2(NUM_FRAMES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CSR_W-1:0]       csr_ff, csr_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [IDX_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                   scan_done_ff, scan_done_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]       h_ff, h_in;
   logic [IDX_W-1:0]       hand_ff, hand_in;
   logic [NUM_FRAMES-1:0]  valid_ff, valid_in;
   logic [NUM_FRAMES-1:0]  ref_ff, ref_in;
   logic [FAULT_W-1:0]     faults_ff, faults_in;
   logic                   res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]       res_idx_ff, res_idx_in;
   logic                   res_vv_ff, res_vv_in;
   logic [PAGE_BITS-1:0]   res_vp_ff, res_vp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]       rsp_idx_ff, rsp_idx_in;
   logic                   rsp_vv_ff, rsp_vv_in;
   logic [PAGE_BITS-1:0]   rsp_vp_ff, rsp_vp_in;
   logic [FAULT_W-1:0]     rsp_fc_ff, rsp_fc_in;

   logic [CNT_W-1:0]       n_eff;
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [PAGE_BITS-1:0]   mem_rd_data;

   function automatic logic [IDX_W-1:0] hand_next(input logic [IDX_W-1:0] h,
                                                   input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] h1;
      h1 = CNT_W'(h) + CNT_W'(1);
      return (h1 >= n) ? '0 : h1[IDX_W-1:0];
   endfunction

   always_comb begin
      priority if (csr_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(csr_ff) > NUM_FRAMES) begin
         n_eff = CNT_W'(NUM_FRAMES);
      end else begin
         n_eff = CNT_W'(csr_ff);
      end
   end

   scp_page_mem #(
      .DEPTH  (NUM_FRAMES),
      .ADDR_W (IDX_W),
      .DATA_W (PAGE_BITS)
   ) u_page_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (h_ff),
      .wr_data (page_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign csr_ready        = 1'b1;
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_index  = rsp_idx_ff;
   assign rsp_victim_valid = rsp_vv_ff;
   assign rsp_victim_page  = rsp_vp_ff;
   assign rsp_fault_count  = rsp_fc_ff;

   always_comb begin
      state_in     = state_ff;
      csr_in       = (csr_valid) ? csr_data : csr_ff;
      page_in      = page_ff;
      scan_addr_in = scan_addr_ff;
      scan_done_in = scan_done_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      h_in         = h_ff;
      hand_in      = hand_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      faults_in    = faults_ff;
      res_hit_in   = res_hit_ff;
      res_idx_in   = res_idx_ff;
      res_vv_in    = res_vv_ff;
      res_vp_in    = res_vp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_vv_in    = rsp_vv_ff;
      rsp_vp_in    = rsp_vp_ff;
      rsp_fc_in    = rsp_fc_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = scan_addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in      = req_page_number;
               scan_addr_in = '0;
               scan_done_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_done_ff) begin
               mem_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_addr_ff;
               if (CNT_W'(scan_addr_ff) + CNT_W'(1) == n_eff) begin
                  scan_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + IDX_W'(1);
               end
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && mem_rd_data == page_ff) begin
                  ref_in[cmp_idx_ff] = 1'b1;
                  res_hit_in         = 1'b1;
                  res_idx_in         = cmp_idx_ff;
                  res_vv_in          = 1'b0;
                  res_vp_in          = '0;
                  cmp_vld_in         = 1'b0;
                  state_in           = ST_DONE;
               end else if (CNT_W'(cmp_idx_ff) + CNT_W'(1) == n_eff) begin
                  h_in       = (CNT_W'(hand_ff) >= n_eff) ? '0 : hand_ff;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (ref_ff[h_ff]) begin
               ref_in[h_ff] = 1'b0;
               h_in         = hand_next(h_ff, n_eff);
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = h_ff;
               state_in    = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_wr_en    = 1'b1;
            res_hit_in   = 1'b0;
            res_idx_in   = h_ff;
            res_vv_in    = valid_ff[h_ff];
            res_vp_in    = (valid_ff[h_ff]) ? mem_rd_data : '0;
            valid_in[h_ff] = 1'b1;
            ref_in[h_ff]   = 1'b0;
            hand_in      = hand_next(h_ff, n_eff);
            if (faults_ff != '1) begin
               faults_in = faults_ff + FAULT_W'(1);
            end
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_vv_in    = res_vv_ff;
               rsp_vp_in    = res_vp_ff;
               rsp_fc_in    = faults_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_W'(CSR_RESET);
         scan_done_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         hand_ff      <= '0;
         valid_ff     <= '0;
         ref_ff       <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         scan_done_ff <= scan_done_in;
         cmp_vld_ff   <= cmp_vld_in;
         hand_ff      <= hand_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff      <= page_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      h_ff         <= h_in;
      res_hit_ff   <= res_hit_in;
      res_idx_ff   <= res_idx_in;
      res_vv_ff    <= res_vv_in;
      res_vp_ff    <= res_vp_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_vv_ff    <= rsp_vv_in;
      rsp_vp_ff    <= rsp_vp_in;
      rsp_fc_ff    <= rsp_fc_in;
   end

   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> !rsp_vv_ff)
      else $error("hit result reports an eviction");

   a_faults_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> faults_ff >= $past(faults_ff))
      else $error("fault count decreased");

   a_fill_clear_ref: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> !ref_ff[h_ff])
      else $error("filling a frame whose reference bit is set");

   a_fill_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL && faults_ff != '1 |=> faults_ff == $past(faults_ff) + FAULT_W'(1))
      else $error("miss did not count a fault");

endmodule : second_chance_page_replacer_unit

`default_nettype wire
